### hw/rtl/mlst_pkg.sv
// Package for the multicast listener source table.
// Sizes, action and status codes, sequencer states and the result struct.
// No dependencies.
package mlst_pkg;
	localparam int GROUP_ENTRIES = 16;
	localparam int SOURCE_SLOTS = 8;
	localparam int EW = (GROUP_ENTRIES > 1) ? $clog2(GROUP_ENTRIES) : 1;
	localparam int SW = (SOURCE_SLOTS > 1) ? $clog2(SOURCE_SLOTS) : 1;
	localparam int SRC_DEPTH = GROUP_ENTRIES * SOURCE_SLOTS;
	localparam int AW = (SRC_DEPTH > 1) ? $clog2(SRC_DEPTH) : 1;

	localparam logic [2:0] ACT_ADD_ALL = 3'd0;
	localparam logic [2:0] ACT_ADD_SRC = 3'd1;
	localparam logic [2:0] ACT_REM_GRP = 3'd2;
	localparam logic [2:0] ACT_REM_SRC = 3'd3;
	localparam logic [2:0] ACT_QRY_GRP = 3'd4;
	localparam logic [2:0] ACT_QRY_SRC = 3'd5;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOT_MC = 2'd1;
	localparam logic [1:0] ST_TBL_FULL = 2'd2;
	localparam logic [1:0] ST_SRC_FULL = 2'd3;

	localparam logic MODE_INCLUDE = 1'b0;
	localparam logic MODE_EXCLUDE = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE, S_GSCAN, S_SREQ, S_SSCAN, S_APPLY, S_OUT
	} state_t;

	typedef struct packed {
		logic       has_listener;
		logic       table_changed;
		logic       group_added;
		logic       group_removed;
		logic [1:0] status;
	} result_t;
endpackage

### hw/rtl/mlst_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module mlst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

### hw/rtl/multicast_listener_source_table.sv
// Multicast listener source table, top level: sequencer, group and slot state,
// one shared 32-bit address comparator. Uses mlst_pkg and mlst_ram.
//
// Usage: one request on s_axis_* carries action, group and source address.
// One result request leaves on m_axis_* for every input request. The block
// takes one request at a time: s_axis_tready is high only while idle.
// Sequence per request: the idle state latches it, then S_GSCAN scans the
// group entries through the shared comparator (the scan stops at a match),
// S_SREQ issues the first source RAM read, S_SSCAN compares the slots for
// source actions, S_APPLY updates the table, then the result is held on
// m_axis_* until taken. A non-source action skips the slot compare.
// Reset clears all valid bits and modes; source RAM content needs no
// clearing since slots are read only where their valid bit is set.
// When the receiver stalls, the result holds on m_axis_tdata and no new
// request is accepted until it is taken.
module multicast_listener_source_table
	import mlst_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [2:0] action, [34:3] group_address, [66:35] source_address, [71:67] zero
	input  logic [71:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [0] has_listener, [1] table_changed, [2] group_added, [3] group_removed,
	// [5:4] status, [7:6] zero
	output logic [7:0]  m_axis_tdata
);
	state_t state_q, state_nx;

	logic [2:0]  act_q;
	logic [31:0] grp_q, src_q;
	logic [GROUP_ENTRIES-1:0] ev_q, mode_q;
	logic [31:0] gstore_q [GROUP_ENTRIES];
	logic [SOURCE_SLOTS-1:0] sv_q [GROUP_ENTRIES];
	logic [EW:0] ecnt_q;
	logic [SW:0] scnt_q;
	logic        gfound_q, sfound_q;
	logic [EW-1:0] eidx_q;
	logic [SW-1:0] sidx_q;
	result_t res_q;

	logic [31:0] cmp_a;
	logic        cmp_eq;
	logic [31:0] rdata;
	logic [AW-1:0] ram_raddr, ram_waddr;
	logic        ram_we_q;
	logic [AW-1:0] waddr_q;

	// shared comparator: group scan or slot scan
	assign cmp_a  = (state_q == S_GSCAN) ? gstore_q[ecnt_q[EW-1:0]] : rdata;
	assign cmp_eq = (cmp_a == ((state_q == S_GSCAN) ? grp_q : src_q));

	logic [AW-1:0] ebase;
	assign ebase = AW'(eidx_q) * AW'(SOURCE_SLOTS);
	assign ram_raddr = ebase + AW'(scnt_q[SW-1:0]);

	// lowest free entry / slot
	logic [EW-1:0] free_e; logic has_free_e;
	logic [SW-1:0] free_s; logic has_free_s;
	always_comb begin
		free_e = '0; has_free_e = 1'b0;
		for (int i = GROUP_ENTRIES - 1; i >= 0; i--)
			if (!ev_q[i]) begin free_e = EW'(i); has_free_e = 1'b1; end
		free_s = '0; has_free_s = 1'b0;
		for (int i = SOURCE_SLOTS - 1; i >= 0; i--)
			if (!sv_q[eidx_q][i]) begin free_s = SW'(i); has_free_s = 1'b1; end
	end
	assign ram_waddr = ebase + AW'(free_s);

	logic src_act;
	assign src_act = (act_q == ACT_ADD_SRC) || (act_q == ACT_REM_SRC) ||
		(act_q == ACT_QRY_SRC);
	logic is_mc;
	assign is_mc = (grp_q[31:28] == 4'hE);

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE:  if (s_axis_tvalid) state_nx = S_GSCAN;
			S_GSCAN: if (ecnt_q == (EW+1)'(GROUP_ENTRIES - 1) ||
				(ev_q[ecnt_q[EW-1:0]] && cmp_eq))
				state_nx = S_SREQ;
			S_SREQ:  state_nx = src_act ? S_SSCAN : S_APPLY;
			S_SSCAN: if (scnt_q == (SW+1)'(SOURCE_SLOTS)) state_nx = S_APPLY;
			S_APPLY: state_nx = S_OUT;
			S_OUT:   if (m_axis_tready) state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_axis_tready = (state_q == S_IDLE);
		m_axis_tvalid = (state_q == S_OUT);
		m_axis_tdata  = {2'b00, res_q.status, res_q.group_removed, res_q.group_added,
			res_q.table_changed, res_q.has_listener};
	end

	// apply decisions
	logic        e_ok;
	logic [EW-1:0] ue;
	logic        umode, listed, accept;
	logic [SOURCE_SLOTS-1:0] usv;
	result_t     res_nx;
	logic        ev_nx, mode_nx, gs_wr, we_nx;
	logic [SOURCE_SLOTS-1:0] sv_nx;
	logic [AW-1:0] waddr_nx;
	always_comb begin
		e_ok = gfound_q; ue = eidx_q; umode = mode_q[eidx_q]; usv = sv_q[eidx_q];
		listed = sfound_q;
		accept = (umode == MODE_INCLUDE) ? listed : !listed;
		res_nx = '0;
		ev_nx = ev_q[eidx_q]; mode_nx = umode; sv_nx = usv;
		gs_wr = 1'b0; we_nx = 1'b0;
		waddr_nx = ram_waddr;
		if (act_q > ACT_QRY_SRC) begin
			res_nx = '0;
		end else if (!is_mc) begin
			res_nx.status = ST_NOT_MC;
		end else if (!e_ok && (act_q == ACT_ADD_ALL || act_q == ACT_ADD_SRC)) begin
			if (!has_free_e) res_nx.status = ST_TBL_FULL;
			else begin
				// new entry is INCLUDE, empty: source not listed
				ev_nx = 1'b1; gs_wr = 1'b1;
				res_nx.group_added = 1'b1; res_nx.table_changed = 1'b1;
				if (act_q == ACT_ADD_ALL) begin
					mode_nx = MODE_EXCLUDE; sv_nx = '0;
				end else begin
					mode_nx = MODE_INCLUDE;
					sv_nx = SOURCE_SLOTS'(1);
					waddr_nx = ebase;
					we_nx = 1'b1;
				end
			end
		end else if (e_ok) begin
			case (act_q)
				ACT_ADD_ALL: if (umode != MODE_EXCLUDE || usv != '0) begin
					mode_nx = MODE_EXCLUDE; sv_nx = '0;
					res_nx.table_changed = 1'b1;
				end
				ACT_ADD_SRC: if (!accept) begin
					if (umode == MODE_INCLUDE) begin
						if (!has_free_s) res_nx.status = ST_SRC_FULL;
						else begin
							sv_nx[free_s] = 1'b1; we_nx = 1'b1;
							res_nx.table_changed = 1'b1;
						end
					end else begin
						sv_nx[sidx_q] = 1'b0;
						res_nx.table_changed = 1'b1;
					end
				end
				ACT_REM_GRP: begin
					ev_nx = 1'b0; mode_nx = MODE_INCLUDE; sv_nx = '0;
					res_nx.table_changed = 1'b1; res_nx.group_removed = 1'b1;
				end
				ACT_REM_SRC: begin
					if (umode == MODE_INCLUDE) begin
						if (listed) begin
							res_nx.table_changed = 1'b1;
							sv_nx[sidx_q] = 1'b0;
						end
						// INCLUDE-empty after this: free it
						if (sv_nx == '0) begin
							ev_nx = 1'b0;
							res_nx.table_changed = 1'b1;
							res_nx.group_removed = 1'b1;
						end
					end else if (!listed) begin
						if (!has_free_s) res_nx.status = ST_SRC_FULL;
						else begin
							sv_nx[free_s] = 1'b1; we_nx = 1'b1;
							res_nx.table_changed = 1'b1;
						end
					end
				end
				ACT_QRY_GRP: res_nx.has_listener = (umode == MODE_EXCLUDE) || (usv != '0);
				ACT_QRY_SRC: res_nx.has_listener = accept;
				default: res_nx = '0;
			endcase
		end
	end

	mlst_ram #(.WIDTH(32), .DEPTH(SRC_DEPTH)) u_src (
		.clk(clk), .we(ram_we_q), .waddr(waddr_q), .wdata(src_q),
		.raddr(ram_raddr), .rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			act_q <= '0; grp_q <= '0; src_q <= '0;
			ev_q <= '0; mode_q <= '0;
			for (int i = 0; i < GROUP_ENTRIES; i++) begin
				sv_q[i] <= '0;
				gstore_q[i] <= '0;
			end
			ecnt_q <= '0; scnt_q <= '0; gfound_q <= 1'b0; sfound_q <= 1'b0;
			eidx_q <= '0; sidx_q <= '0; res_q <= '0; ram_we_q <= 1'b0;
			waddr_q <= '0;
		end else begin
			state_q <= state_nx;
			ram_we_q <= (state_q == S_APPLY) && we_nx;
			case (state_q)
				S_IDLE: if (s_axis_tvalid) begin
					act_q <= s_axis_tdata[2:0];
					grp_q <= s_axis_tdata[34:3];
					src_q <= s_axis_tdata[66:35];
					ecnt_q <= '0; gfound_q <= 1'b0;
				end
				S_GSCAN: begin
					if (ev_q[ecnt_q[EW-1:0]] && cmp_eq) begin
						gfound_q <= 1'b1; eidx_q <= ecnt_q[EW-1:0];
					end else if (ecnt_q == (EW+1)'(GROUP_ENTRIES - 1)) begin
						eidx_q <= free_e;
					end
					ecnt_q <= ecnt_q + 1'b1;
					scnt_q <= '0; sfound_q <= 1'b0;
				end
				S_SREQ: scnt_q <= scnt_q + 1'b1;
				S_SSCAN: begin
					// rdata is for slot scnt_q-1
					if (sv_q[eidx_q][scnt_q[SW-1:0] - 1'b1] && cmp_eq && !sfound_q
						&& gfound_q) begin
						sfound_q <= 1'b1; sidx_q <= scnt_q[SW-1:0] - 1'b1;
					end
					if (scnt_q != (SW+1)'(SOURCE_SLOTS)) scnt_q <= scnt_q + 1'b1;
				end
				S_APPLY: begin
					res_q <= res_nx;
					waddr_q <= waddr_nx;
					ev_q[ue] <= ev_nx;
					mode_q[ue] <= mode_nx;
					sv_q[ue] <= sv_nx;
					if (gs_wr) gstore_q[ue] <= grp_q;
				end
				default: ;
			endcase
		end
	end
endmodule

### test/tb_multicast_listener_source_table.sv
// Testbench for the multicast listener source table: stream driver and monitor,
// an internal table predictor and a request-by-request compare of every result.
// Depends on mlst_pkg and multicast_listener_source_table.
module tb_multicast_listener_source_table
	import mlst_pkg::*;
();

	typedef struct {
		logic [2:0]  action;
		logic [31:0] grp;
		logic [31:0] src;
	} request_t;

	localparam int LIMIT_CYCLES = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam logic [2:0] ACT_NOP = 3'd6;
	localparam logic [2:0] ACT_NOP_HI = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [71:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;

	multicast_listener_source_table dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predictor state
	logic        ent_valid [GROUP_ENTRIES];
	logic [31:0] ent_group [GROUP_ENTRIES];
	logic        ent_mode [GROUP_ENTRIES];
	logic [SOURCE_SLOTS-1:0] ent_slots [GROUP_ENTRIES];
	logic [31:0] ent_src [GROUP_ENTRIES][SOURCE_SLOTS];

	request_t pending_requests[$];
	result_t  expected_results[$];
	int errors = 0, sent = 0, received = 0, cycles = 0;
	int snd_idle = 15, rcv_idle = 88;
	int hold_cnt = 0;
	logic hold_start = 1'b0, hold_used = 1'b0;
	int queries_yes = 0, frees = 0, fulls = 0;

	function automatic int find_src(int e, logic [31:0] s);
		for (int k = 0; k < SOURCE_SLOTS; k++)
			if (ent_slots[e][k] && ent_src[e][k] == s) return k;
		return -1;
	endfunction

	function automatic int free_src(int e);
		for (int k = 0; k < SOURCE_SLOTS; k++)
			if (!ent_slots[e][k]) return k;
		return -1;
	endfunction

	function automatic result_t table_update(request_t r);
		result_t res;
		int e, k;
		logic listed;
		res = '0;
		e = -1;
		if (r.action > ACT_QRY_SRC) return res;
		if (r.grp[31:28] != 4'hE) begin
			res.status = ST_NOT_MC;
			return res;
		end
		for (int i = 0; i < GROUP_ENTRIES; i++)
			if (e < 0 && ent_valid[i] && ent_group[i] == r.grp) e = i;
		if ((r.action == ACT_ADD_ALL || r.action == ACT_ADD_SRC) && e < 0) begin
			for (int i = 0; i < GROUP_ENTRIES; i++)
				if (e < 0 && !ent_valid[i]) e = i;
			if (e >= 0) begin
				ent_valid[e] = 1'b1;
				ent_group[e] = r.grp;
				ent_mode[e] = MODE_INCLUDE;
				ent_slots[e] = '0;
				res.group_added = 1'b1;
				res.table_changed = 1'b1;
			end else
				res.status = ST_TBL_FULL;
		end
		if (e < 0) return res;
		k = find_src(e, r.src);
		listed = (k >= 0);
		case (r.action)
			ACT_ADD_ALL: begin
				if (ent_mode[e] != MODE_EXCLUDE || ent_slots[e] != 0) begin
					ent_mode[e] = MODE_EXCLUDE;
					ent_slots[e] = '0;
					res.table_changed = 1'b1;
				end
			end
			ACT_ADD_SRC: begin
				if (ent_mode[e] == MODE_INCLUDE && !listed) begin
					k = free_src(e);
					if (k < 0) res.status = ST_SRC_FULL;
					else begin
						ent_src[e][k] = r.src;
						ent_slots[e][k] = 1'b1;
						res.table_changed = 1'b1;
					end
				end else if (ent_mode[e] == MODE_EXCLUDE && listed) begin
					ent_slots[e][k] = 1'b0;
					res.table_changed = 1'b1;
				end
			end
			ACT_REM_GRP: begin
				ent_valid[e] = 1'b0;
				ent_mode[e] = MODE_INCLUDE;
				ent_slots[e] = '0;
				res.table_changed = 1'b1;
				res.group_removed = 1'b1;
			end
			ACT_REM_SRC: begin
				if (ent_mode[e] == MODE_INCLUDE) begin
					if (listed) begin
						ent_slots[e][k] = 1'b0;
						res.table_changed = 1'b1;
					end
				end else if (!listed) begin
					k = free_src(e);
					if (k < 0) res.status = ST_SRC_FULL;
					else begin
						ent_src[e][k] = r.src;
						ent_slots[e][k] = 1'b1;
						res.table_changed = 1'b1;
					end
				end
				// include with nothing left frees the entry
				if (ent_mode[e] == MODE_INCLUDE && ent_slots[e] == 0) begin
					ent_valid[e] = 1'b0;
					res.table_changed = 1'b1;
					res.group_removed = 1'b1;
				end
			end
			ACT_QRY_GRP: res.has_listener = (ent_mode[e] == MODE_EXCLUDE) || (ent_slots[e] != 0);
			default: res.has_listener = (ent_mode[e] == MODE_INCLUDE) ? listed : !listed;
		endcase
		return res;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		errors++;
		$display("mismatch at result %0d: %s got %0d expected %0d", received, what, got, want);
	endtask

	task automatic queue_request(request_t r);
		pending_requests.insert(pending_requests.size(), r);
	endtask

	// driver
	always @(posedge clk) begin
		request_t r;
		result_t pred;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				sent++;
				pred = table_update(request_t'{
					s_axis_tdata[2:0], s_axis_tdata[34:3], s_axis_tdata[66:35]});
				expected_results.insert(expected_results.size(), pred);
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_requests.size() > 0 && $urandom_range(99) >= snd_idle) begin
					r = pending_requests.pop_front();
					s_axis_tdata <= {5'b0, r.src, r.grp, r.action};
					s_axis_tvalid <= 1'b1;
				end else
					s_axis_tvalid <= 1'b0;
			end
		end
	end

	// long receiver hold-off, started once
	always @(posedge clk) begin
		if (hold_start && !hold_used) begin
			hold_cnt <= HOLD_CYCLES;
			hold_used <= 1'b1;
		end else if (hold_cnt > 0)
			hold_cnt <= hold_cnt - 1;
	end

	// monitor
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			cycles++;
			if (m_axis_tvalid && m_axis_tready) begin
				received++;
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result", m_axis_tdata, 0);
				end else begin
					want = expected_results.pop_front();
					if (m_axis_tdata[0] && want.has_listener) queries_yes++;
					if (want.group_removed) frees++;
					if (want.status >= ST_TBL_FULL) fulls++;
					if (m_axis_tdata[0] !== want.has_listener)
						report_mismatch("has_listener", m_axis_tdata[0], want.has_listener);
					if (m_axis_tdata[1] !== want.table_changed)
						report_mismatch("table_changed", m_axis_tdata[1], want.table_changed);
					if (m_axis_tdata[2] !== want.group_added)
						report_mismatch("group_added", m_axis_tdata[2], want.group_added);
					if (m_axis_tdata[3] !== want.group_removed)
						report_mismatch("group_removed", m_axis_tdata[3], want.group_removed);
					if (m_axis_tdata[5:4] !== want.status)
						report_mismatch("status", m_axis_tdata[5:4], want.status);
					if (m_axis_tdata[7:6] !== 2'b00)
						report_mismatch("pad bits", m_axis_tdata[7:6], 0);
				end
			end
			if (hold_cnt > 0)
				m_axis_tready <= 1'b0;
			else
				m_axis_tready <= ($urandom_range(99) >= rcv_idle);
			if (cycles > LIMIT_CYCLES) begin
				$display("timeout after %0d cycles", cycles);
				$display("tb_multicast_listener_source_table: done, errors");
				$finish;
			end
		end
	end

	function automatic logic [31:0] mc_group(int idx);
		return {4'hE, 28'h0000100 + idx[27:0]};
	endfunction

	function automatic request_t rand_request();
		request_t r;
		int pick;
		pick = $urandom_range(99);
		r.action = 3'($urandom_range(ACT_QRY_SRC));
		if (pick < 85) begin
			// small pools so entries and sources collide often
			r.grp = mc_group($urandom_range(19));
			if ($urandom_range(3) != 0) r.src = 32'h0A00_0000 + 32'($urandom_range(11));
			else r.src = $urandom;
		end else begin
			r.grp = $urandom;
			r.src = $urandom;
			if (pick >= 97) r.action = 3'($urandom_range(ACT_NOP, ACT_NOP_HI));
		end
		if (r.action == ACT_REM_GRP && $urandom_range(2) != 0) r.action = ACT_ADD_SRC;
		return r;
	endfunction

	task automatic drain();
		while (pending_requests.size() > 0 || expected_results.size() > 0 || s_axis_tvalid)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	initial begin
		for (int i = 0; i < GROUP_ENTRIES; i++) begin
			ent_valid[i] = 1'b0;
			ent_mode[i] = MODE_INCLUDE;
			ent_slots[i] = '0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		// directed: bad addresses, every action, source overflow, table overflow
		queue_request('{ACT_ADD_ALL, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
		queue_request('{ACT_QRY_GRP, 32'h0000_0000, 32'h0});
		queue_request('{ACT_QRY_GRP, 32'hE000_0000, 32'h0});
		queue_request('{ACT_NOP, 32'hE000_0000, 32'h0});
		queue_request('{ACT_NOP_HI, 32'hEFFF_FFFF, 32'hFFFF_FFFF});
		for (int k = 0; k <= SOURCE_SLOTS; k++)
			queue_request('{ACT_ADD_SRC, 32'hE000_0000, 32'($urandom) ^ k});
		queue_request('{ACT_QRY_SRC, 32'hE000_0000, 32'hFFFF_FFFF});
		queue_request('{ACT_ADD_ALL, 32'hE000_0000, 32'h0});
		queue_request('{ACT_REM_SRC, 32'hE000_0000, 32'h0});
		queue_request('{ACT_QRY_SRC, 32'hE000_0000, 32'h0});
		queue_request('{ACT_ADD_SRC, 32'hE000_0000, 32'h0});
		queue_request('{ACT_REM_GRP, 32'hE000_0000, 32'h0});
		queue_request('{ACT_REM_SRC, 32'hE000_0000, 32'h0});
		for (int i = 0; i <= GROUP_ENTRIES; i++)
			queue_request('{ACT_ADD_ALL, mc_group(100 + i), 32'h0});
		drain();
		for (int i = 0; i < GROUP_ENTRIES; i++)
			queue_request('{ACT_REM_GRP, mc_group(100 + i), 32'h0});
		for (int ph = 0; ph < 3; ph++) begin
			snd_idle = (ph == 0) ? 15 : (ph == 1) ? 88 : 0;
			rcv_idle = (ph == 0) ? 88 : (ph == 1) ? 15 : 0;
			if (ph == 2) hold_start = 1'b1;
			for (int i = 0; i < 130; i++) queue_request(rand_request());
			drain();
		end
		$display("requests %0d, results %0d, positive answers %0d, frees %0d, full codes %0d",
			sent, received, queries_yes, frees, fulls);
		$display("covered bad groups, all actions, slot and table overflow, %0d-cycle stall",
			HOLD_CYCLES);
		if (errors == 0)
			$display("tb_multicast_listener_source_table: done, clean");
		else
			$display("tb_multicast_listener_source_table: done, errors");
		$finish;
	end
endmodule
